// ===== sv/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon block
// Coordinate widths, request and result structs, register indexes.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int CW = 32;          // coordinate width, signed Q24.8
	localparam int DW = CW + 1;      // coordinate difference
	localparam int PW = 2 * DW;      // product of two differences
	localparam int NREG = 2;
	localparam int IW = $clog2(NREG);

	localparam logic [IW-1:0] REG_QUERY_X = IW'(0);
	localparam logic [IW-1:0] REG_QUERY_Y = IW'(1);

	typedef struct packed {
		logic signed [CW-1:0] vertex_x;
		logic signed [CW-1:0] vertex_y;
		logic                 ring_end;
		logic                 polygon_end;
	} vtx_t;

	typedef struct packed {
		logic inside_res;
		logic outer_inside;
	} res_t;

endpackage

// ===== sv/point_in_polygon_with_holes.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_with_holes: crossing-number test over a vertex stream
// Tests the previous edge and the ring closing edge of each vertex, exact
// cross-multiplied compare, even-odd parity per ring and over rings.
// ----------------------------------------------------------------------------
// The last vertex passes stages 1 and 2, then sets the result valid register.
// Throughput: one vertex per cycle; set by the two-stage multiply/compare path.
// Input stalls only while a finished result is held and another is in stage 2.
// Reset: query point 0, ring state cleared, first ring taken as outer ring.
module point_in_polygon_with_holes import pip_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [IW-1:0] cfg_idx,
	input  logic [CW-1:0] cfg_wdata,
	input  logic          vtx_valid,
	output logic          vtx_stall,
	input  vtx_t          vtx,
	output logic          res_valid,
	input  logic          res_stall,
	output res_t          res
);

	typedef struct packed {
		logic                 straddle;
		logic signed [DW-1:0] dy;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic signed [DW-1:0] c;
	} edge_t;

	typedef struct packed {
		logic                 straddle;
		logic                 dy_neg;
		logic signed [PW-1:0] lhs;
		logic signed [PW-1:0] rhs;
	} prod_t;

	function automatic edge_t edge_prep(
		input logic signed [CW-1:0] xi, input logic signed [CW-1:0] yi,
		input logic signed [CW-1:0] xj, input logic signed [CW-1:0] yj,
		input logic signed [CW-1:0] px, input logic signed [CW-1:0] py);
		edge_t e;
		e.straddle = (yi > py) != (yj > py);
		e.dy = DW'(yj) - DW'(yi);
		e.a  = DW'(px) - DW'(xi);
		e.b  = DW'(xj) - DW'(xi);
		e.c  = DW'(py) - DW'(yi);
		return e;
	endfunction

	function automatic prod_t edge_mul(input edge_t e);
		prod_t p;
		p.straddle = e.straddle;
		p.dy_neg   = e.dy[DW-1];
		p.lhs      = PW'(e.a) * PW'(e.dy);
		p.rhs      = PW'(e.b) * PW'(e.c);
		return p;
	endfunction

	function automatic logic edge_cross(input prod_t p);
		return p.straddle && (p.dy_neg ? (p.rhs < p.lhs) : (p.lhs < p.rhs));
	endfunction

	logic signed [CW-1:0] query_x_q, query_y_q;
	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                 ring_open_q;
	logic                 ring_par_q, on_outer_q, outer_hit_q, hit_par_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic  v_s1, v_s2;
	logic  rend_s1, rend_s2, pend_s1, pend_s2;
	edge_t ea_s1, eb_s1;
	prod_t pa_s2, pb_s2;

	logic                 accept, hold, adv, rend_in;
	logic signed [CW-1:0] fx, fy;
	edge_t                ea_d, eb_d;
	logic                 par_nx, outer_hit_nx, hit_par_nx;

	assign hold      = res_valid_q && res_stall && v_s2 && pend_s2;
	assign adv       = !hold;
	assign vtx_stall = hold;
	assign accept    = vtx_valid && !vtx_stall;
	assign rend_in   = vtx.ring_end || vtx.polygon_end;

	assign fx = ring_open_q ? first_x_q : vtx.vertex_x;
	assign fy = ring_open_q ? first_y_q : vtx.vertex_y;

	always_comb begin
		ea_d = edge_prep(vtx.vertex_x, vtx.vertex_y, prev_x_q, prev_y_q, query_x_q, query_y_q);
		ea_d.straddle = ea_d.straddle && ring_open_q;
		eb_d = edge_prep(fx, fy, vtx.vertex_x, vtx.vertex_y, query_x_q, query_y_q);
		eb_d.straddle = eb_d.straddle && rend_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_QUERY_X: query_x_q <= cfg_wdata;
				REG_QUERY_Y: query_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ring tracking on the request side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			ring_open_q <= 1'b0;
		end else if (accept) begin
			first_x_q   <= fx;
			first_y_q   <= fy;
			prev_x_q    <= vtx.vertex_x;
			prev_y_q    <= vtx.vertex_y;
			ring_open_q <= !rend_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ea_s1   <= ea_d;
			eb_s1   <= eb_d;
			rend_s1 <= rend_in;
			pend_s1 <= vtx.polygon_end;
			pa_s2   <= edge_mul(ea_s1);
			pb_s2   <= edge_mul(eb_s1);
			rend_s2 <= rend_s1;
			pend_s2 <= pend_s1;
		end
	end

	always_comb begin
		par_nx       = ring_par_q ^ edge_cross(pa_s2) ^ edge_cross(pb_s2);
		outer_hit_nx = (rend_s2 && on_outer_q) ? par_nx : outer_hit_q;
		hit_par_nx   = rend_s2 ? (hit_par_q ^ par_nx) : hit_par_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_par_q  <= 1'b0;
			on_outer_q  <= 1'b1;
			outer_hit_q <= 1'b0;
			hit_par_q   <= 1'b0;
		end else if (adv && v_s2) begin
			ring_par_q  <= rend_s2 ? 1'b0 : par_nx;
			if (pend_s2) begin
				on_outer_q  <= 1'b1;
				outer_hit_q <= 1'b0;
				hit_par_q   <= 1'b0;
			end else begin
				on_outer_q  <= on_outer_q && !rend_s2;
				outer_hit_q <= outer_hit_nx;
				hit_par_q   <= hit_par_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && v_s2 && pend_s2) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && pend_s2) begin
			res_q.inside_res   <= outer_hit_nx && hit_par_nx;
			res_q.outer_inside <= outer_hit_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/pip_chk.sv =====
// ----------------------------------------------------------------------------
// pip_chk: port-level checks for point_in_polygon_with_holes
// Watches the request and result channels; bound to point_in_polygon_with_holes.
// ----------------------------------------------------------------------------
module pip_chk import pip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic vtx_valid,
	input logic vtx_stall,
	input vtx_t vtx,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// requests back up only behind a result that is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_stall |-> (res_valid && res_stall))
		else $error("request stalled with no held result");

	a_inside_outer: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.inside_res) |-> res.outer_inside)
		else $error("inside without outer ring hit");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result dropped or changed");

	a_vtx_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid && vtx_stall) |=> $past(res_valid))
		else $error("stall seen without a pending result");

endmodule

bind point_in_polygon_with_holes pip_chk u_pip_chk (.*);

// ===== test/tb_point_in_polygon_with_holes.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_with_holes: vertex stream crossing-number checker
// Streams polygons with holes into the block and predicts each inside/outer
// verdict with an exact even-odd crossing model kept in the bench. Directed
// shapes cover default query, nested rings, degenerate rings and coordinate
// extremes. Random polygons, most of them around the query point, follow under
// bursty requests and random result stalls.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_with_holes;
	import pip_pkg::*;

	localparam int PIPE_SLACK = 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_VERTICES = 800;

	typedef enum {SPREAD_TIGHT, SPREAD_WIDE, SPREAD_ANY} spread_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [IW-1:0] cfg_idx = '0;
	logic [CW-1:0] cfg_wdata = '0;
	logic          vtx_valid = 1'b0;
	logic          vtx_stall;
	vtx_t          vtx = '0;
	logic          res_valid;
	logic          res_stall = 1'b0;
	res_t          res;

	point_in_polygon_with_holes dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.vtx_valid(vtx_valid),
		.vtx_stall(vtx_stall),
		.vtx(vtx),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #10 clk = ~clk;

	// crossing model state
	logic signed [CW-1:0] qry_x = '0;
	logic signed [CW-1:0] qry_y = '0;
	logic signed [CW-1:0] ring_x0 = '0;
	logic signed [CW-1:0] ring_y0 = '0;
	logic signed [CW-1:0] last_x = '0;
	logic signed [CW-1:0] last_y = '0;
	bit ring_started = 1'b0;
	bit ring_odd = 1'b0;
	bit in_outer = 1'b1;
	bit outer_odd = 1'b0;
	bit rings_odd = 1'b0;
	res_t expected_verdicts[$];

	int error_count = 0;
	int vertices_sent = 0;
	int burst_left = 0;
	int gap_max = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	res_t verdict_want;

	function automatic bit edge_flips(input logic signed [CW-1:0] xi, yi, xj, yj);
		logic signed [DW-1:0] dy, dxq, dxe, dyq;
		logic signed [PW-1:0] lhs, rhs;
		if ((yi > qry_y) == (yj > qry_y))
			return 1'b0;
		dy = DW'(yj) - DW'(yi);
		dxq = DW'(qry_x) - DW'(xi);
		dxe = DW'(xj) - DW'(xi);
		dyq = DW'(qry_y) - DW'(yi);
		lhs = PW'(dxq) * PW'(dy);
		rhs = PW'(dxe) * PW'(dyq);
		return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
	endfunction

	task automatic track_vertex(input vtx_t v);
		bit closes;
		res_t want;
		closes = v.ring_end | v.polygon_end;
		if (!ring_started) begin
			ring_x0 = v.vertex_x;
			ring_y0 = v.vertex_y;
		end else if (edge_flips(v.vertex_x, v.vertex_y, last_x, last_y)) begin
			ring_odd = !ring_odd;
		end
		last_x = v.vertex_x;
		last_y = v.vertex_y;
		ring_started = 1'b1;
		if (closes) begin
			if (edge_flips(ring_x0, ring_y0, v.vertex_x, v.vertex_y))
				ring_odd = !ring_odd;
			if (in_outer)
				outer_odd = ring_odd;
			rings_odd = rings_odd ^ ring_odd;
			in_outer = 1'b0;
			ring_started = 1'b0;
			ring_odd = 1'b0;
		end
		if (v.polygon_end) begin
			want.inside_res = outer_odd & rings_odd;
			want.outer_inside = outer_odd;
			expected_verdicts.insert(expected_verdicts.size(), want);
			in_outer = 1'b1;
			outer_odd = 1'b0;
			rings_odd = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// send one vertex request, bursty, then predict on accept
	task automatic send_vertex(input logic [CW-1:0] x, y, input bit rend, pend);
		int gap;
		vtx_t v;
		v.vertex_x = x;
		v.vertex_y = y;
		v.ring_end = rend;
		v.polygon_end = pend;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				vtx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		vtx_valid <= 1'b1;
		vtx <= v;
		do @(posedge clk); while (vtx_stall);
		track_vertex(v);
		vertices_sent++;
	endtask

	// stop requests and wait for the pipe to empty
	task automatic settle();
		vtx_valid <= 1'b0;
		burst_left = 0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_QUERY_X: qry_x = val;
			REG_QUERY_Y: qry_y = val;
			default: ;
		endcase
	endtask

	task automatic set_query(input logic [CW-1:0] x, y);
		write_reg(REG_QUERY_X, x);
		write_reg(REG_QUERY_Y, y);
	endtask

	function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] centre,
		input spread_t spread);
		int unit;
		unit = ($urandom_range(0, 1) == 1) ? 256 : 1;
		case (spread)
			SPREAD_TIGHT: return centre + CW'((int'($urandom_range(0, 8)) - 4) * unit);
			SPREAD_WIDE: return centre + CW'(int'($urandom_range(0, 16383)) - 8192);
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic send_random_polygon(input spread_t spread);
		int rings, n;
		bit drop_end, rend, pend;
		rings = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 4);
		drop_end = ($urandom_range(0, 3) == 0);
		for (int r = 0; r < rings; r++) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			for (int k = 0; k < n; k++) begin
				rend = (k == n - 1);
				pend = rend && (r == rings - 1);
				if (pend && drop_end)
					rend = 1'b0;
				send_vertex(near_coord(qry_x, spread), near_coord(qry_y, spread), rend, pend);
			end
		end
	endtask

	// query left at its reset value
	task automatic test_reset_query();
		send_vertex(-32'sd256, -32'sd256, 1'b0, 1'b0);
		send_vertex(32'sd256, -32'sd256, 1'b0, 1'b0);
		send_vertex(32'sd0, 32'sd256, 1'b1, 1'b1);
	endtask

	task automatic test_nested_rings();
		// outer, hole and island all around the point
		send_vertex(-32'sd4096, -32'sd4096, 1'b0, 1'b0);
		send_vertex(32'sd4096, -32'sd4096, 1'b0, 1'b0);
		send_vertex(32'sd0, 32'sd4096, 1'b1, 1'b0);
		send_vertex(-32'sd1024, -32'sd1024, 1'b0, 1'b0);
		send_vertex(32'sd1024, -32'sd1024, 1'b0, 1'b0);
		send_vertex(32'sd0, 32'sd1024, 1'b1, 1'b0);
		send_vertex(-32'sd256, -32'sd256, 1'b0, 1'b0);
		send_vertex(32'sd256, -32'sd256, 1'b0, 1'b0);
		send_vertex(32'sd0, 32'sd256, 1'b1, 1'b1);
		// outer plus hole only
		send_vertex(-32'sd4096, -32'sd4096, 1'b0, 1'b0);
		send_vertex(32'sd4096, -32'sd4096, 1'b0, 1'b0);
		send_vertex(32'sd0, 32'sd4096, 1'b1, 1'b0);
		send_vertex(-32'sd1024, -32'sd1024, 1'b0, 1'b0);
		send_vertex(32'sd1024, -32'sd1024, 1'b0, 1'b0);
		send_vertex(32'sd0, 32'sd1024, 1'b1, 1'b1);
	endtask

	task automatic test_degenerate_rings();
		// lone vertex, polygon end without ring end
		send_vertex(32'sd512, 32'sd0, 1'b0, 1'b1);
		// two-vertex ring through the point
		send_vertex(-32'sd256, -32'sd256, 1'b0, 1'b0);
		send_vertex(32'sd256, 32'sd256, 1'b1, 1'b1);
	endtask

	task automatic test_coord_extremes();
		set_query(32'h7FFF_FFFF, 32'h8000_0000);
		send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
		set_query(32'h8000_0000, 32'h0000_0000);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
	endtask

	task automatic test_random_polygons();
		int phase_end, pick;
		spread_t spread;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_query(32'h7FFF_FFFF, 32'h8000_0000);
				1: set_query(32'h8000_0000, 32'h7FFF_FFFF);
				2: set_query('0, '0);
				default: set_query($urandom, $urandom);
			endcase
			gap_max = (phase % 3) * 3;
			stall_pct = (phase % 4) * 25;
			phase_end = vertices_sent + RANDOM_VERTICES / 8;
			while (vertices_sent < phase_end) begin
				pick = $urandom_range(0, 9);
				spread = (pick < 6) ? SPREAD_TIGHT : (pick < 9) ? SPREAD_WIDE : SPREAD_ANY;
				send_random_polygon(spread);
				if ($urandom_range(0, 15) == 0)
					settle();
			end
		end
	endtask

	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected result inside_res", res.inside_res, 0);
			end else begin
				verdict_want = expected_verdicts.pop_front();
				if (res.inside_res !== verdict_want.inside_res)
					report_mismatch("inside_res", res.inside_res, verdict_want.inside_res);
				if (res.outer_inside !== verdict_want.outer_inside)
					report_mismatch("outer_inside", res.outer_inside, verdict_want.outer_inside);
			end
		end
	end

	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_max = 2;
		stall_pct = 20;
		test_reset_query();
		test_nested_rings();
		test_degenerate_rings();
		test_coord_extremes();
		test_random_polygons();
		settle();
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_verdicts.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
